@@ sv/perlin_noise_2d_octave_sum_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Perlin octave sum block
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERLIN_NOISE_2D_OCTAVE_SUM_DEFINES_SVH
`define PERLIN_NOISE_2D_OCTAVE_SUM_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PN2D_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PN2D_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/pn2d_pkg.sv @@
// ----------------------------------------------------------------------------
// pn2d_pkg
// Shared types and constants of the Perlin octave sum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pn2d_pkg;

	localparam int MAX_OCTAVES_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int OFS_W  = 16;
	localparam int GRAD_W = 2;
	localparam int SUM_W  = 21;
	localparam int CNT_W  = 5;

	// Fade polynomial 6t^5 - 15t^4 + 10t^3.
	localparam int FADE_C6  = 6;
	localparam int FADE_C15 = 15;
	localparam int FADE_C10 = 10;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_F1,
		S_F2,
		S_F3,
		S_F4,
		S_F5,
		S_L1,
		S_L2,
		S_L3,
		S_L4,
		S_L5,
		S_ACC,
		S_EMIT
	} state_t;

	typedef struct packed {
		state_t st;
		logic   fsel;
		logic   idle;
	} ctl_t;

	typedef struct packed {
		logic go;
		logic skip;
		logic last;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

@@ sv/pn2d_div.sv @@
// ----------------------------------------------------------------------------
// pn2d_div
// Two-lane radix-2 restoring divider that turns the x and y offsets into
// fractions of the cell size, one quotient bit per lane and cycle while step is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pn2d_div #(
	parameter int QB = pn2d_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       step,
	input  logic [pn2d_pkg::OFS_W-1:0] num_x,
	input  logic [pn2d_pkg::OFS_W-1:0] num_y,
	input  logic [pn2d_pkg::OFS_W-1:0] den,
	output logic [QB-1:0]              q_x,
	output logic [QB-1:0]              q_y,
	output logic                       last
);
	import pn2d_pkg::*;

	localparam int CW = (QB > 1) ? $clog2(QB) : 1;

	logic [OFS_W-1:0] rx_q, ry_q, den_q;
	logic [QB-1:0]    qx_q, qy_q;
	logic [CW-1:0]    cnt_q;
	logic [OFS_W:0]   sx, sy;

	// Returns the quotient bit on top of the new partial remainder.
	function automatic logic [OFS_W:0] div_bit(input logic [OFS_W-1:0] r,
		input logic [OFS_W-1:0] d);
		logic [OFS_W:0] r2;
		logic [OFS_W:0] diff;
		r2   = {r, 1'b0};
		diff = r2 - {1'b0, d};
		if (r2 >= {1'b0, d})
			return {1'b1, diff[OFS_W-1:0]};
		else
			return {1'b0, r2[OFS_W-1:0]};
	endfunction

	assign sx = div_bit(rx_q, den_q);
	assign sy = div_bit(ry_q, den_q);

	always_ff @(posedge clk) begin
		if (load) begin
			rx_q  <= num_x;
			ry_q  <= num_y;
			den_q <= den;
		end else if (step) begin
			rx_q <= sx[OFS_W-1:0];
			ry_q <= sy[OFS_W-1:0];
			qx_q <= {qx_q[QB-2:0], sx[OFS_W]};
			qy_q <= {qy_q[QB-2:0], sy[OFS_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	assign q_x  = qx_q;
	assign q_y  = qy_q;
	assign last = (cnt_q == CW'(QB - 1));

endmodule

@@ sv/pn2d_mul.sv @@
// ----------------------------------------------------------------------------
// pn2d_mul
// Shared signed multiplier with a registered product, used for the fade
// polynomial and for the three interpolations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pn2d_mul #(
	parameter int W = pn2d_pkg::FRAC_BITS_DEF + 5
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);
	import pn2d_pkg::*;

	logic signed [2*W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

@@ sv/pn2d_ctrl.sv @@
// ----------------------------------------------------------------------------
// pn2d_ctrl
// Sequencer that walks one octave through divide, fade, interpolate and
// accumulate steps on the shared units; skipped octaves only accumulate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pn2d_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  pn2d_pkg::sts_t sts,
	output pn2d_pkg::ctl_t ctl
);
	import pn2d_pkg::*;

	state_t state_q, state_d;
	logic   fsel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fsel_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sts.go)
				fsel_q <= 1'b0;
			else if (state_q == S_F5)
				fsel_q <= ~fsel_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (sts.go)
					state_d = sts.skip ? S_ACC : S_DIV;
			end
			S_DIV: begin
				if (sts.div_last)
					state_d = S_F1;
			end
			S_F1: state_d = S_F2;
			S_F2: state_d = S_F3;
			S_F3: state_d = S_F4;
			S_F4: state_d = S_F5;
			// The fade runs twice, first for x and then for y.
			S_F5: state_d = fsel_q ? S_L1 : S_F1;
			S_L1: state_d = S_L2;
			S_L2: state_d = S_L3;
			S_L3: state_d = S_L4;
			S_L4: state_d = S_L5;
			S_L5: state_d = S_ACC;
			S_ACC: state_d = sts.last ? S_EMIT : S_IDLE;
			S_EMIT: begin
				if (sts.out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl.st   = state_q;
		ctl.fsel = fsel_q;
		ctl.idle = (state_q == S_IDLE);
	end

endmodule

@@ sv/perlin_noise_2d_octave_sum.sv @@
// ----------------------------------------------------------------------------
// perlin_noise_2d_octave_sum
// One octave of 2D Perlin gradient noise per transfer, summed over octaves.
// Each accepted item is worked on alone, and no new item is taken until it
// is through: an accept step, the divide in the two-lane divider, the fade
// on the shared multiplier (for x, then for y), the interpolations on the
// same multiplier and an accumulate step, with an emit step on the octave
// marked last. Octaves past MAX_OCTAVES skip the arithmetic. The result
// sits in an output register, so the next octave may start while it waits;
// only a second last octave waits for it to be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "perlin_noise_2d_octave_sum_defines.svh"

module perlin_noise_2d_octave_sum #(
	parameter int MAX_OCTAVES = pn2d_pkg::MAX_OCTAVES_DEF,
	parameter int FRAC_BITS   = pn2d_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pt_valid,
	output logic                               pt_stall,
	input  logic        [pn2d_pkg::OFS_W-1:0]  offset_x,
	input  logic        [pn2d_pkg::OFS_W-1:0]  offset_y,
	input  logic        [pn2d_pkg::OFS_W-1:0]  cell_size,
	input  logic signed [pn2d_pkg::GRAD_W-1:0] grad_a_x,
	input  logic signed [pn2d_pkg::GRAD_W-1:0] grad_a_y,
	input  logic signed [pn2d_pkg::GRAD_W-1:0] grad_b_x,
	input  logic signed [pn2d_pkg::GRAD_W-1:0] grad_b_y,
	input  logic signed [pn2d_pkg::GRAD_W-1:0] grad_c_x,
	input  logic signed [pn2d_pkg::GRAD_W-1:0] grad_c_y,
	input  logic signed [pn2d_pkg::GRAD_W-1:0] grad_d_x,
	input  logic signed [pn2d_pkg::GRAD_W-1:0] grad_d_y,
	input  logic                               last_octave,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic signed [pn2d_pkg::SUM_W-1:0]  noise_sum,
	output logic        [pn2d_pkg::CNT_W-1:0]  octave_count
);
	import pn2d_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int TW = F + 1;          // fractions and fades, 1.0 included
	localparam int DW = F + 4;          // dot products and interpolations
	localparam int MW = F + 5;          // multiplier operands
	localparam int PW = 2 * MW;
	localparam int QW = F + 6;
	localparam int AW = ((DW > SUM_W) ? DW : SUM_W) + 1;

	localparam logic [TW-1:0]        ONE_T = TW'(1) << F;
	localparam logic signed [DW-1:0] ONE_D = DW'(1) <<< F;
	localparam logic signed [QW-1:0] C10_Q = QW'(FADE_C10) <<< F;
	localparam logic signed [AW-1:0] S_MAX = (AW'(1) <<< (SUM_W - 1)) - AW'(1);
	localparam logic signed [AW-1:0] S_MIN = -(AW'(1) <<< (SUM_W - 1));

	ctl_t ctl;
	sts_t sts;

	logic pt_xfer, res_xfer, out_free, skip, div_last;
	logic [F-1:0] qx, qy;

	logic [7:0][GRAD_W-1:0] grad_q;
	logic last_q, sat_x_q, sat_y_q;

	logic [TW-1:0]        frac_x, frac_y, t_sel, p_lo;
	logic signed [DW-1:0] fxs, fys, fxm, fym;
	logic signed [DW-1:0] dot_c [4];
	logic signed [DW-1:0] dot_q [4];

	logic signed [MW-1:0]   mul_a, mul_b, t_m;
	logic signed [PW-1:0]   mul_p, p_sh;
	logic signed [DW+1:0]   lsh;
	logic signed [QW-1:0]   t_ext, t6, t15, p_q6, qf_c;

	logic [F+3:0]         qf_q;
	logic [TW-1:0]        u_q, v_q;
	logic signed [DW-1:0] top_q, bot_q, noise_q;

	logic signed [SUM_W-1:0] sum_q, noise_sum_q;
	logic [CNT_W-1:0]        ws_q, octave_count_q;
	logic                    res_valid_q;
	logic signed [DW-1:0]    contrib;
	logic signed [AW-1:0]    acc_s;
	logic signed [SUM_W-1:0] sat_c;

	// Gradient component times a fraction; components are small, so a
	// selection replaces the multiply.
	function automatic logic signed [DW-1:0] grad_term(input logic [GRAD_W-1:0] g,
		input logic signed [DW-1:0] f);
		case (g)
			2'b01:   return f;
			2'b11:   return -f;
			2'b10:   return -(f <<< 1);
			default: return '0;
		endcase
	endfunction

	function automatic logic signed [DW-1:0] lerp_add(input logic signed [DW-1:0] a,
		input logic signed [DW+1:0] d);
		logic signed [DW+1:0] s;
		s = {{2{a[DW-1]}}, a} + d;
		return s[DW-1:0];
	endfunction

	assign pt_xfer  = pt_valid && !pt_stall;
	assign res_xfer = res_valid_q && !res_stall;
	assign out_free = !res_valid_q || !res_stall;
	assign skip     = (ws_q >= CNT_W'(MAX_OCTAVES));

	always_comb begin
		sts.go       = pt_xfer;
		sts.skip     = skip;
		sts.last     = last_q;
		sts.div_last = div_last;
		sts.out_free = out_free;
	end

	pn2d_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	pn2d_div #(
		.QB (F)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (pt_xfer),
		.step   (ctl.st == S_DIV),
		.num_x  (offset_x),
		.num_y  (offset_y),
		.den    (cell_size),
		.q_x    (qx),
		.q_y    (qy),
		.last   (div_last)
	);

	pn2d_mul #(
		.W (MW)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// An offset at or beyond the cell size, or a zero cell size, gives 1.0.
	assign frac_x = sat_x_q ? ONE_T : {1'b0, qx};
	assign frac_y = sat_y_q ? ONE_T : {1'b0, qy};
	assign fxs    = $signed(DW'(frac_x));
	assign fys    = $signed(DW'(frac_y));
	assign fxm    = fxs - ONE_D;
	assign fym    = fys - ONE_D;

	always_comb begin
		dot_c[0] = grad_term(grad_q[0], fxs) + grad_term(grad_q[1], fys);
		dot_c[1] = grad_term(grad_q[2], fxm) + grad_term(grad_q[3], fys);
		dot_c[2] = grad_term(grad_q[4], fxs) + grad_term(grad_q[5], fym);
		dot_c[3] = grad_term(grad_q[6], fxm) + grad_term(grad_q[7], fym);
	end

	assign t_sel = ctl.fsel ? frac_y : frac_x;
	assign t_m   = $signed(MW'(t_sel));
	assign t_ext = $signed(QW'(t_sel));
	assign t6    = t_ext * QW'(FADE_C6);
	assign t15   = t_ext * QW'(FADE_C15);

	// Products of the fade are never negative; the interpolation products
	// are floored by the arithmetic shift.
	assign p_sh = mul_p >>> F;
	assign p_lo = p_sh[TW-1:0];
	assign lsh  = p_sh[DW+1:0];
	assign p_q6 = p_sh[QW-1:0];
	assign qf_c = p_q6 - t15 + C10_Q;

	// The squared and cubed terms are fed back straight from the product
	// register, so each fade step starts in the cycle after the one before.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.st)
			S_F1: begin
				mul_a = MW'(t6);
				mul_b = t_m;
			end
			S_F2: begin
				mul_a = t_m;
				mul_b = t_m;
			end
			S_F3: begin
				mul_a = $signed(MW'(p_lo));
				mul_b = t_m;
			end
			S_F4: begin
				mul_a = $signed(MW'(p_lo));
				mul_b = $signed(MW'(qf_q));
			end
			S_L1: begin
				mul_a = MW'(dot_q[1]) - MW'(dot_q[0]);
				mul_b = $signed(MW'(u_q));
			end
			S_L2: begin
				mul_a = MW'(dot_q[3]) - MW'(dot_q[2]);
				mul_b = $signed(MW'(u_q));
			end
			S_L4: begin
				mul_a = MW'(bot_q) - MW'(top_q);
				mul_b = $signed(MW'(v_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (ctl.st)
			S_IDLE: begin
				if (pt_xfer) begin
					grad_q  <= {grad_d_y, grad_d_x, grad_c_y, grad_c_x,
						grad_b_y, grad_b_x, grad_a_y, grad_a_x};
					last_q  <= last_octave;
					sat_x_q <= (cell_size == '0) || (offset_x >= cell_size);
					sat_y_q <= (cell_size == '0) || (offset_y >= cell_size);
				end
			end
			S_F1: dot_q <= dot_c;
			S_F2: qf_q <= qf_c[F+3:0];
			S_F5: begin
				if (ctl.fsel)
					v_q <= p_lo;
				else
					u_q <= p_lo;
			end
			S_L2: top_q <= lerp_add(dot_q[0], lsh);
			S_L3: bot_q <= lerp_add(dot_q[2], lsh);
			S_L5: noise_q <= lerp_add(top_q, lsh);
			S_EMIT: begin
				if (out_free) begin
					noise_sum_q    <= sum_q;
					octave_count_q <= ws_q;
				end
			end
			default: ;
		endcase
	end

	// Octave k is weighted by 2^-k; the sum saturates to the output range.
	assign contrib = noise_q >>> ws_q;
	assign acc_s   = AW'(sum_q) + AW'(contrib);

	always_comb begin
		if (acc_s > S_MAX)
			sat_c = S_MAX[SUM_W-1:0];
		else if (acc_s < S_MIN)
			sat_c = S_MIN[SUM_W-1:0];
		else
			sat_c = acc_s[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			ws_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.st == S_ACC && !skip) begin
				sum_q <= sat_c;
				ws_q  <= ws_q + CNT_W'(1);
			end else if (ctl.st == S_EMIT && out_free) begin
				sum_q <= '0;
				ws_q  <= '0;
			end
			if (ctl.st == S_EMIT && out_free)
				res_valid_q <= 1'b1;
			else if (res_xfer)
				res_valid_q <= 1'b0;
		end
	end

	assign pt_stall     = !ctl.idle;
	assign res_valid    = res_valid_q;
	assign noise_sum    = noise_sum_q;
	assign octave_count = octave_count_q;

	`PN2D_ASSERT_IMP(a_ws_bound, 1'b1, ws_q <= CNT_W'(MAX_OCTAVES), "octave count beyond limit")
	`PN2D_ASSERT_NXT(a_busy_after_xfer, pt_xfer, pt_stall, "input not stalled after transfer")
	`PN2D_ASSERT_NXT(a_ws_step, (ctl.st == S_ACC) && !skip, ws_q == $past(ws_q) + CNT_W'(1), "octave count did not advance")
	`PN2D_ASSERT_NXT(a_emit_clear, (ctl.st == S_EMIT) && out_free, res_valid && (sum_q == '0) && (ws_q == '0), "emit did not clear the sum")

endmodule
